>>> rtl/http_byte_range_parser_assert.svh
// assertion helpers for the range parser, sampled on clk and held off during rst
`ifndef HTTP_BYTE_RANGE_PARSER_ASSERT_SVH
`define HTTP_BYTE_RANGE_PARSER_ASSERT_SVH

// condition implies property in the same cycle
`define HBR_ASSERT_NOW(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// condition implies property in the next cycle
`define HBR_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

>>> rtl/hbr_pkg.sv
package hbr_pkg;

  // width of the object length port and of the result offsets
  localparam int OBJ_W = 40;
  localparam int OUT_W = 40;

  localparam int PREFIX_LEN = 6;

  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_DASH = 8'h2d;

  // parse phase, one-hot
  typedef enum logic [2:0] {
    PH_PREFIX = 3'b001,
    PH_START  = 3'b010,
    PH_END    = 3'b100
  } phase_t;

  // expected character of the "bytes=" prefix at a given position
  function automatic logic [7:0] prefix_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0: c = 8'h62;    // b
      3'd1: c = 8'h79;    // y
      3'd2: c = 8'h74;    // t
      3'd3: c = 8'h65;    // e
      3'd4: c = 8'h73;    // s
      3'd5: c = 8'h3d;    // =
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

>>> rtl/http_byte_range_parser.sv
// an accepted transaction is held in the input register and parsed from there; an end item's
//   result is loaded into the result register and offered on out_valid from then on
// throughput: one character per cycle, limited only by the end item needing a free result slot
// reset (rst, synchronous, active high): empties both stages, parse returns to the prefix
//   phase with all totals and the held object length at zero
module http_byte_range_parser
  import hbr_pkg::*;
#(
  parameter int LEN_BITS = 40
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       ch,
  input  logic             is_end,
  input  logic             first,
  input  logic [OBJ_W-1:0] obj_len,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             valid_res,
  output logic [OUT_W-1:0] range_low,
  output logic [OUT_W-1:0] range_high,
  output logic [OUT_W-1:0] part_length
);

`include "http_byte_range_parser_assert.svh"

  // totals carry four extra bits so that acc*10+d never wraps before the saturation check
  localparam int ACC_W = LEN_BITS + 4;
  localparam logic [LEN_BITS-1:0] LEN_MAX = '1;
  localparam logic [LEN_BITS-1:0] LEN_ONE = LEN_BITS'(1);

  // input stage
  logic                hold_valid;
  logic [7:0]          hold_ch;
  logic                hold_end;
  logic                hold_first;
  logic [LEN_BITS-1:0] hold_len;

  // parse state
  phase_t              phase;
  logic [2:0]          prefix_index;
  logic [LEN_BITS-1:0] start_total;
  logic [LEN_BITS-1:0] end_total;
  logic                has_start;
  logic                has_end;
  logic                failed;
  logic [LEN_BITS-1:0] length_held;

  // result register
  logic                res_ok;
  logic [LEN_BITS-1:0] res_lo;
  logic [LEN_BITS-1:0] res_hi;
  logic [LEN_BITS-1:0] res_part;

  // state as seen by this character (after a restart on first)
  phase_t              ph_cur;
  logic [2:0]          pidx_cur;
  logic [LEN_BITS-1:0] st_cur;
  logic [LEN_BITS-1:0] en_cur;
  logic                hs_cur;
  logic                he_cur;
  logic                fl_cur;
  logic [LEN_BITS-1:0] len_cur;

  phase_t              phase_next;
  logic [2:0]          prefix_index_next;
  logic [LEN_BITS-1:0] start_total_next;
  logic [LEN_BITS-1:0] end_total_next;
  logic                has_start_next;
  logic                has_end_next;
  logic                failed_next;

  logic                is_digit;
  logic [3:0]          dval;
  logic [ACC_W-1:0]    st_mul;
  logic [ACC_W-1:0]    en_mul;
  logic [LEN_BITS-1:0] st_sat;
  logic [LEN_BITS-1:0] en_sat;

  logic [LEN_BITS-1:0] hi_max;
  logic [LEN_BITS-1:0] lo_sfx;
  logic [LEN_BITS-1:0] lo_sel;
  logic [LEN_BITS-1:0] hi_sel;
  logic [LEN_BITS-1:0] part_sel;
  logic                form_ok;
  logic                ok_sel;

  logic                out_free;
  logic                step_go;

  // the result slot is free when empty or being drained this cycle
  assign out_free = !out_valid || out_ready;
  // a character moves on at once; an end item waits for the result slot
  assign step_go  = hold_valid && (!hold_end || out_free);
  assign in_ready = !hold_valid || step_go;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_ch    <= ch;
      hold_end   <= is_end;
      hold_first <= first;
      hold_len   <= LEN_BITS'(obj_len);
    end
  end

  // first restarts the parse and samples the length before the character is used
  always_comb begin
    ph_cur   = phase;
    pidx_cur = prefix_index;
    st_cur   = start_total;
    en_cur   = end_total;
    hs_cur   = has_start;
    he_cur   = has_end;
    fl_cur   = failed;
    len_cur  = length_held;
    if (hold_first) begin
      ph_cur   = PH_PREFIX;
      pidx_cur = 3'd0;
      st_cur   = '0;
      en_cur   = '0;
      hs_cur   = 1'b0;
      he_cur   = 1'b0;
      fl_cur   = 1'b0;
      len_cur  = hold_len;
    end
  end

  // decimal accumulate, saturating at the top of the length range
  assign is_digit = (hold_ch >= CH_ZERO) && (hold_ch <= CH_NINE);
  assign dval     = 4'(hold_ch - CH_ZERO);
  assign st_mul   = ACC_W'({st_cur, 3'b000}) + ACC_W'({st_cur, 1'b0}) + ACC_W'(dval);
  assign en_mul   = ACC_W'({en_cur, 3'b000}) + ACC_W'({en_cur, 1'b0}) + ACC_W'(dval);
  assign st_sat   = (|st_mul[ACC_W-1:LEN_BITS]) ? LEN_MAX : st_mul[LEN_BITS-1:0];
  assign en_sat   = (|en_mul[ACC_W-1:LEN_BITS]) ? LEN_MAX : en_mul[LEN_BITS-1:0];

  // grammar step for one character
  always_comb begin
    phase_next        = ph_cur;
    prefix_index_next = pidx_cur;
    start_total_next  = st_cur;
    end_total_next    = en_cur;
    has_start_next    = hs_cur;
    has_end_next      = he_cur;
    failed_next       = fl_cur;
    if (hold_end) begin
      // end of header: back to the prefix phase, held length kept
      phase_next        = PH_PREFIX;
      prefix_index_next = 3'd0;
      start_total_next  = '0;
      end_total_next    = '0;
      has_start_next    = 1'b0;
      has_end_next      = 1'b0;
      failed_next       = 1'b0;
    end else if (!fl_cur) begin
      case (ph_cur)
        PH_PREFIX: begin
          if (pidx_cur >= 3'(PREFIX_LEN) || hold_ch != prefix_char(pidx_cur)) begin
            failed_next = 1'b1;
          end else begin
            prefix_index_next = pidx_cur + 3'd1;
            if (pidx_cur == 3'(PREFIX_LEN - 1)) begin
              phase_next = PH_START;
            end
          end
        end
        PH_START: begin
          if (is_digit) begin
            start_total_next = st_sat;
            has_start_next   = 1'b1;
          end else if (hold_ch == CH_DASH) begin
            // a start at or past the object end is unsatisfiable
            if (st_cur >= len_cur) begin
              failed_next = 1'b1;
            end else begin
              phase_next = PH_END;
            end
          end else begin
            failed_next = 1'b1;
          end
        end
        PH_END: begin
          if (is_digit) begin
            end_total_next = en_sat;
            has_end_next   = 1'b1;
          end else begin
            failed_next = 1'b1;
          end
        end
        default: begin
          failed_next = 1'b1;
        end
      endcase
    end
  end

  // range forming on the end item
  assign form_ok  = !fl_cur && (ph_cur == PH_END) && (len_cur != '0) && (hs_cur || he_cur);
  assign hi_max   = len_cur - LEN_ONE;
  // suffix form: last N bytes, a suffix longer than the object starts at zero
  assign lo_sfx   = (en_cur >= len_cur) ? '0 : (len_cur - en_cur);
  assign lo_sel   = hs_cur ? st_cur : lo_sfx;
  // closed form: end clamped to the last byte
  assign hi_sel   = (hs_cur && he_cur && (en_cur < hi_max)) ? en_cur : hi_max;
  assign part_sel = hi_sel - lo_sel + LEN_ONE;
  assign ok_sel   = form_ok && !(lo_sel > hi_sel);

  // parse state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_PREFIX;
      prefix_index <= 3'd0;
      start_total  <= '0;
      end_total    <= '0;
      has_start    <= 1'b0;
      has_end      <= 1'b0;
      failed       <= 1'b0;
      length_held  <= '0;
    end else if (step_go) begin
      phase        <= phase_next;
      prefix_index <= prefix_index_next;
      start_total  <= start_total_next;
      end_total    <= end_total_next;
      has_start    <= has_start_next;
      has_end      <= has_end_next;
      failed       <= failed_next;
      length_held  <= len_cur;
    end
  end

  // result register, loaded only by an end item
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step_go && hold_end) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_go && hold_end) begin
      res_ok   <= ok_sel;
      res_lo   <= ok_sel ? lo_sel : '0;
      res_hi   <= ok_sel ? hi_sel : '0;
      res_part <= ok_sel ? part_sel : '0;
    end
  end

  assign valid_res   = res_ok;
  assign range_low   = OUT_W'(res_lo);
  assign range_high  = OUT_W'(res_hi);
  assign part_length = OUT_W'(res_part);

  // a reported range is never inverted
  `HBR_ASSERT_NOW(a_range_order, out_valid && res_ok, res_lo <= res_hi, "range low above high")

  // a rejected range reports all zero
  `HBR_ASSERT_NOW(a_reject_zero, out_valid && !res_ok,
                  res_lo == '0 && res_hi == '0 && res_part == '0, "rejected range not zero")

  // an end item that moves on always leaves a result and a clean parse behind
  `HBR_ASSERT_NEXT(a_end_result, step_go && hold_end,
                   out_valid && phase == PH_PREFIX && prefix_index == 3'd0 && !failed,
                   "end item without result or parse restart")

  // the end digits are only ever reached through a matched prefix and a dash
  `HBR_ASSERT_NOW(a_end_phase, phase == PH_END, prefix_index == 3'(PREFIX_LEN),
                  "end phase without full prefix")

endmodule

>>> tb/tb_top.sv
module tb_top
  import hbr_pkg::*;
();

  localparam int LEN_BITS = 40;
  localparam logic [63:0] LEN_TOP = (64'd1 << LEN_BITS) - 64'd1;
  localparam logic [7:0] RANGE_UNIT [PREFIX_LEN] = '{"b", "y", "t", "e", "s", "="};
  // item counts: main random part, then a final stretch with no idling
  localparam int MAIN_ITEMS = 390;
  localparam int TOTAL_ITEMS = 450;
  // cycles with no transaction on either side before the run is abandoned
  localparam int STALL_LIMIT = 4000;
  // length of the one long receiver hold-off, and the result count that sets it off
  localparam int HOLD_CYCLES = 150;
  localparam int HOLD_AFTER = 30;

  typedef logic [7:0] txt_q_t[$];

  // one character transaction as offered to the parser
  typedef struct {
    logic [7:0]       c;
    logic             fin;
    logic             head;
    logic [OBJ_W-1:0] olen;
  } char_item_t;

  // one expected parse outcome
  typedef struct packed {
    logic             ok;
    logic [OUT_W-1:0] low;
    logic [OUT_W-1:0] high;
    logic [OUT_W-1:0] span;
  } range_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [7:0]       ch = 8'h00;
  logic             is_end = 1'b0;
  logic             first = 1'b0;
  logic [OBJ_W-1:0] obj_len = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic             valid_res;
  logic [OUT_W-1:0] range_low;
  logic [OUT_W-1:0] range_high;
  logic [OUT_W-1:0] part_length;

  char_item_t pend_q[$];
  range_t     range_q[$];

  bit gaps_on = 1'b1;
  int unsigned items_queued = 0;
  int unsigned headers_queued = 0;
  int unsigned items_in = 0;
  int unsigned results_seen = 0;
  int unsigned ranges_ok = 0;
  int unsigned err_cnt = 0;
  int unsigned quiet_cycles = 0;

  // predicted parser state
  phase_t      p_phase;
  int          p_pos;
  logic [63:0] p_start;
  logic [63:0] p_stop;
  logic        p_got_start;
  logic        p_got_stop;
  logic        p_bad;
  logic [63:0] p_len;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  http_byte_range_parser #(.LEN_BITS(LEN_BITS)) dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .ch          (ch),
    .is_end      (is_end),
    .first       (first),
    .obj_len     (obj_len),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .valid_res   (valid_res),
    .range_low   (range_low),
    .range_high  (range_high),
    .part_length (part_length)
  );

  task automatic flag_error(input string msg);
    err_cnt++;
    if (err_cnt <= 10) $display("%s", msg);
  endtask

  // ---------------------------------------------------------------- prediction

  task automatic restart_parse();
    p_phase     = PH_PREFIX;
    p_pos       = 0;
    p_start     = '0;
    p_stop      = '0;
    p_got_start = 1'b0;
    p_got_stop  = 1'b0;
    p_bad       = 1'b0;
  endtask

  // decimal accumulate, pinned at the top of the length range
  function automatic logic [63:0] grow_total(input logic [63:0] acc, input logic [63:0] d);
    if (acc > (LEN_TOP - d) / 64'd10) return LEN_TOP;
    return acc * 64'd10 + d;
  endfunction

  task automatic consume_char(input logic [7:0] c);
    logic is_digit;
    is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    if (!p_bad) begin
      case (p_phase)
        PH_PREFIX: begin
          if (p_pos >= PREFIX_LEN || c != RANGE_UNIT[p_pos]) begin
            p_bad = 1'b1;
          end else begin
            p_pos++;
            if (p_pos == PREFIX_LEN) p_phase = PH_START;
          end
        end
        PH_START: begin
          if (is_digit) begin
            p_start     = grow_total(p_start, 64'(c - CH_ZERO));
            p_got_start = 1'b1;
          end else if (c == CH_DASH) begin
            // start at or past the object end is caught on the dash
            if (p_start >= p_len) p_bad = 1'b1;
            else p_phase = PH_END;
          end else begin
            p_bad = 1'b1;
          end
        end
        PH_END: begin
          if (is_digit) begin
            p_stop     = grow_total(p_stop, 64'(c - CH_ZERO));
            p_got_stop = 1'b1;
          end else begin
            p_bad = 1'b1;
          end
        end
        default: p_bad = 1'b1;
      endcase
    end
  endtask

  // end of header: work out the range and queue it, then start over
  task automatic close_header();
    range_t      r;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] span;
    logic        ok;
    r  = '0;
    lo = '0;
    hi = '0;
    ok = !p_bad && p_phase == PH_END && p_len != 0 && (p_got_start || p_got_stop);
    if (ok) begin
      hi = p_len - 64'd1;
      if (!p_got_start) begin
        // suffix form, longer than the object means the whole object
        lo = (p_stop >= p_len) ? 64'd0 : p_len - p_stop;
      end else begin
        lo = p_start;
        if (p_got_stop && p_stop < hi) hi = p_stop;
      end
      if (lo > hi) ok = 1'b0;
    end
    if (ok) begin
      span   = hi - lo + 64'd1;
      r.ok   = 1'b1;
      r.low  = lo[OUT_W-1:0];
      r.high = hi[OUT_W-1:0];
      r.span = span[OUT_W-1:0];
    end
    range_q.push_back(r);
    restart_parse();
  endtask

  task automatic take_item(input logic [7:0] c, input logic fin, input logic head,
                           input logic [OBJ_W-1:0] olen);
    if (head) begin
      restart_parse();
      p_len = 64'(olen);
    end
    if (fin) close_header();
    else consume_char(c);
  endtask

  // ---------------------------------------------------------------- stimulus helpers

  function automatic logic [OBJ_W-1:0] noise_len();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    if (w[OBJ_W-1:0] == '0) w = 64'd1;
    return w[OBJ_W-1:0];
  endfunction

  // object length of random magnitude, small ones common, now and then the top
  function automatic logic [63:0] any_len();
    logic [63:0] v;
    v = 64'(noise_len()) >> (OBJ_W - $urandom_range(1, OBJ_W));
    if ($urandom_range(0, 19) == 0) v = LEN_TOP;
    if (v == 0) v = 64'd1;
    return v;
  endfunction

  // offsets around the interesting points of the object
  function automatic logic [63:0] pick_offset(input logic [63:0] len);
    logic [63:0] v;
    case ($urandom_range(0, 7))
      0:       v = 64'd0;
      1:       v = len - 64'd1;
      2:       v = len;
      3:       v = len + 64'd1;
      4, 5:    v = {$urandom(), $urandom()} % len;
      6:       v = 64'(noise_len());
      default: v = {$urandom(), $urandom()};   // well past saturation
    endcase
    return v;
  endfunction

  function automatic txt_q_t to_bytes(input string s);
    txt_q_t q;
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    return q;
  endfunction

  task automatic push_item(input logic [7:0] c, input logic fin, input logic head,
                           input logic [OBJ_W-1:0] olen);
    char_item_t it;
    it.c    = c;
    it.fin  = fin;
    it.head = head;
    it.olen = olen;
    pend_q.push_back(it);
    items_queued++;
  endtask

  // one header: its characters, then the closing transaction with a junk character
  task automatic send_header(input txt_q_t t, input logic [OBJ_W-1:0] olen, input bit head);
    for (int i = 0; i < t.size(); i++)
      push_item(t[i], 1'b0, head && i == 0, (i == 0) ? olen : noise_len());
    push_item(8'($urandom_range(0, 255)), 1'b1, head && t.size() == 0,
              (t.size() == 0) ? olen : noise_len());
    headers_queued++;
  endtask

  task automatic queue_random_header();
    logic [63:0] len;
    logic [63:0] a;
    logic [63:0] b;
    txt_q_t      t;
    string       s;
    int          kind;
    int          k;
    len  = any_len();
    a    = pick_offset(len);
    b    = pick_offset(len);
    kind = $urandom_range(0, 11);
    case (kind)
      4, 5:    s = $sformatf("bytes=%0d-", a);
      6, 7:    s = $sformatf("bytes=-%0d", b);
      8:       s = "";
      9:       s = "bytes=";
      default: s = $sformatf("bytes=%0d-%0d", a, b);
    endcase
    t = to_bytes(s);
    if (kind == 8) begin
      // raw noise
      repeat ($urandom_range(0, 10)) t.push_back(8'($urandom_range(0, 255)));
    end else if (kind == 9) begin
      // prefix then a jumble of digits and dashes
      repeat ($urandom_range(0, 8)) begin
        k = $urandom_range(0, 10);
        t.push_back((k == 10) ? CH_DASH : CH_ZERO + 8'(k));
      end
    end else if (kind == 10) begin
      t[$urandom_range(0, t.size() - 1)] = 8'($urandom_range(0, 255));
    end else if (kind == 11) begin
      repeat ($urandom_range(1, t.size())) void'(t.pop_back());
    end
    send_header(t, len[OBJ_W-1:0], $urandom_range(0, 9) != 0);
  endtask

  // ---------------------------------------------------------------- driver

  always @(posedge clk) begin : feed
    char_item_t  nx;
    logic        live;
    int unsigned gap_left;
    if (rst) begin
      in_valid <= 1'b0;
      gap_left = 0;
      restart_parse();
      p_len = '0;
    end else begin
      live = in_valid;
      if (in_valid && in_ready) begin
        take_item(ch, is_end, first, obj_len);
        items_in++;
        live = 1'b0;
      end
      // a new character is only loaded once the previous one has gone
      if (!live) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (pend_q.size() != 0) begin
          if (gaps_on && $urandom_range(0, 9) == 0) begin
            gap_left = $urandom_range(1, 10) - 1;
          end else begin
            nx      = pend_q.pop_front();
            ch      <= nx.c;
            is_end  <= nx.fin;
            first   <= nx.head;
            obj_len <= nx.olen;
            live    = 1'b1;
          end
        end
      end
      in_valid <= live;
    end
  end

  // ---------------------------------------------------------------- monitor

  always @(posedge clk) begin : sink
    range_t      want;
    logic        rdy;
    int unsigned stall_left;
    int unsigned hold_left;
    bit          held;
    if (rst) begin
      out_ready <= 1'b0;
      stall_left = 0;
      hold_left  = 0;
      held       = 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (valid_res) ranges_ok++;
        if (range_q.size() == 0) begin
          flag_error($sformatf("tb_top: unexpected result valid_res=%0b low=%0d high=%0d len=%0d",
                               valid_res, range_low, range_high, part_length));
        end else begin
          want = range_q.pop_front();
          if (want !== {valid_res, range_low, range_high, part_length})
            flag_error($sformatf({"tb_top: result %0d mismatch:",
                                  " got valid_res=%0b low=%0d high=%0d len=%0d,",
                                  " expected valid_res=%0b low=%0d high=%0d len=%0d"},
                                 results_seen, valid_res, range_low, range_high,
                                 part_length, want.ok, want.low, want.high, want.span));
        end
        // one long hold-off so the parser backs up and stalls its input
        if (results_seen == HOLD_AFTER && !held) begin
          hold_left = HOLD_CYCLES;
          held      = 1'b1;
        end
      end
      if (hold_left != 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        rdy = 1'b0;
      end else if (gaps_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 10) - 1;
        rdy        = 1'b0;
      end else begin
        rdy = 1'b1;
      end
      out_ready <= rdy;
    end
  end

  // ---------------------------------------------------------------- watchdog

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
      $display("tb_top: no transaction for %0d cycles, %0d results outstanding",
               STALL_LIMIT, range_q.size());
      $display("tb_top: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin : stim
    txt_q_t      t;
    txt_q_t      none;
    logic [63:0] mid;
    mid = LEN_TOP - 64'd1;

    // directed headers, queued during reset
    // no first flag straight after reset: held length is zero
    send_header(to_bytes("bytes=0-5"), 40'd1000, 1'b0);
    send_header(to_bytes("bytes=0-499"), 40'd1000, 1'b1);
    send_header(to_bytes("bytes=500-"), 40'd1000, 1'b1);
    // no first flag, parsed against the length held from before
    send_header(to_bytes("bytes=-200"), 40'd77, 1'b0);
    send_header(to_bytes("bytes=-5000"), 40'd1000, 1'b1);
    send_header(to_bytes("bytes=-0"), 40'd1000, 1'b1);
    send_header(to_bytes("bytes=-"), 40'd1000, 1'b1);
    send_header(to_bytes("bytes=1000-"), 40'd1000, 1'b1);
    send_header(to_bytes("bytes=999-999"), 40'd1000, 1'b1);
    send_header(to_bytes("bytes=50-10"), 40'd1000, 1'b1);
    send_header(to_bytes("bytes=0-99999999"), 40'd100, 1'b1);
    // totals that run past the top of the range
    send_header(to_bytes("bytes=99999999999999999999-"), LEN_TOP[OBJ_W-1:0], 1'b1);
    send_header(to_bytes("bytes=0-99999999999999999999"), LEN_TOP[OBJ_W-1:0], 1'b1);
    send_header(to_bytes("bytes=-99999999999999999999"), LEN_TOP[OBJ_W-1:0], 1'b1);
    send_header(to_bytes($sformatf("bytes=%0d-%0d", mid, mid)), LEN_TOP[OBJ_W-1:0], 1'b1);
    send_header(to_bytes("bytes=0-0"), 40'd1, 1'b1);
    // grammar breakers: second dash, letter, wrong case, doubled equals
    send_header(to_bytes("bytes=1-2-3"), 40'd1000, 1'b1);
    send_header(to_bytes("bytes=a-5"), 40'd1000, 1'b1);
    send_header(to_bytes("Bytes=0-1"), 40'd1000, 1'b1);
    send_header(to_bytes("bytes==1-2"), 40'd1000, 1'b1);
    // nul byte among the end digits
    t    = to_bytes("bytes=1-9");
    t[8] = 8'h00;
    send_header(t, 40'd1000, 1'b1);
    // short headers, and an empty one with first and end together
    send_header(to_bytes("bytes=12"), 40'd1000, 1'b1);
    send_header(to_bytes("bytes="), 40'd1000, 1'b1);
    send_header(none, 40'd1000, 1'b1);
    // abandoned partial prefix, then a fresh header restarts the parse
    push_item("b", 1'b0, 1'b1, 40'd500);
    push_item("y", 1'b0, 1'b0, 40'd3);
    send_header(to_bytes("bytes=10-20"), 40'd500, 1'b1);

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // random headers, mostly well formed
    while (items_queued < MAIN_ITEMS) queue_random_header();
    while (pend_q.size() != 0) @(posedge clk);

    // closing stretch at full rate on both sides
    gaps_on = 1'b0;
    while (items_queued < TOTAL_ITEMS) queue_random_header();

    while (pend_q.size() != 0 || in_valid || range_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (range_q.size() != 0)
      flag_error($sformatf("tb_top: %0d results never arrived", range_q.size()));

    $display("tb_top: %0d headers sent as %0d characters, %0d results checked",
             headers_queued, items_in, results_seen);
    $display("tb_top: %0d satisfiable ranges, %0d mismatches", ranges_ok, err_cnt);
    if (err_cnt == 0) $display("tb_top: done, clean");
    else $display("tb_top: done, errors");
    $finish;
  end

endmodule
